/* rtl/core/gpio_port_with_config_lock_defines.svh */
// Assertion macros shared by the port's modules.
`ifndef GPIO_PORT_WITH_CONFIG_LOCK_DEFINES_SVH
`define GPIO_PORT_WITH_CONFIG_LOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* rtl/core/gpio_lk_pkg.sv */
`default_nettype none
package gpio_lk_pkg;

   localparam logic       ACC_READ  = 1'b0;
   localparam logic       ACC_WRITE = 1'b1;

   localparam logic [2:0] SEL_CFG_LOW  = 3'd0;
   localparam logic [2:0] SEL_CFG_HIGH = 3'd1;
   localparam logic [2:0] SEL_INPUT    = 3'd2;
   localparam logic [2:0] SEL_OUTPUT   = 3'd3;
   localparam logic [2:0] SEL_LOCK     = 3'd4;

   localparam logic [1:0] KEY_IDLE  = 2'd0;
   localparam logic [1:0] KEY_ONE   = 2'd1;
   localparam logic [1:0] KEY_TWO   = 2'd2;
   localparam logic [1:0] KEY_THREE = 2'd3;

   localparam logic [31:0] CFG_RESET = 32'h4444_4444;
   localparam logic [3:0]  NIBBLE    = 4'hF;
   localparam int          KEY_BIT   = 16;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  reg_select;
      logic [31:0] write_data;
      logic [15:0] pin_levels;
      logic        soft_reset;
   } gpio_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_drive;
      logic [31:0] pin_config_low;
      logic [31:0] pin_config_high;
      logic        lock_active;
   } gpio_rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } gpio_cmd_type;

endpackage
`default_nettype wire

/* rtl/core/gpio_port_with_config_lock.sv */
`default_nettype none
// Sixteen-pin I/O port register block with a configuration lock. A request is taken when
// start is high and busy is low; its result is registered into rsp_payload at the end of the
// execute state and is shown in the respond state, marked by rsp_valid for exactly one cycle,
// and must be captured then because the receiver cannot stall the block. One request is in
// flight at a time: the controller steps through its accept, execute and respond states and
// takes no new request until it is back in idle. The lock key sequence and the soft reset
// carried in the request act in the execute cycle.
module gpio_port_with_config_lock
   import gpio_lk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire gpio_req_type req_payload,
   output logic              rsp_valid,
   output gpio_rsp_type      rsp_payload
);

   gpio_cmd_type cmd;

   gpio_lk_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   gpio_lk_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* rtl/core/gpio_lk_datapath.sv */
`default_nettype none
`include "gpio_port_with_config_lock_defines.svh"
module gpio_lk_datapath
   import gpio_lk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire gpio_cmd_type cmd,
   input  wire gpio_req_type req_payload,
   output gpio_rsp_type      rsp_payload
);

   gpio_req_type req_ff;
   gpio_rsp_type rsp_ff, rsp_in;
   logic [31:0]  cfg_low_ff, cfg_low_in;
   logic [31:0]  cfg_high_ff, cfg_high_in;
   logic [15:0]  out_latch_ff, out_latch_in;
   logic [15:0]  locked_ff, locked_in;
   logic         lock_key_ff, lock_key_in;
   logic [1:0]   key_step_ff, key_step_in;
   logic [15:0]  pending_ff, pending_in;
   logic [31:0]  frozen_low, frozen_high;
   logic [31:0]  read_val;
   logic [15:0]  wr_mask;
   logic         wr_key;
   logic         mask_match;
   logic         step_ok;

   assign wr_mask    = req_ff.write_data[15:0];
   assign wr_key     = req_ff.write_data[KEY_BIT];
   assign mask_match = (wr_mask == pending_ff);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         frozen_low[4*i +: 4]  = (lock_key_ff && locked_ff[i])     ? NIBBLE : 4'h0;
         frozen_high[4*i +: 4] = (lock_key_ff && locked_ff[8 + i]) ? NIBBLE : 4'h0;
      end
   end

   always_comb begin
      case (key_step_ff)
         KEY_IDLE: step_ok = wr_key;
         KEY_ONE:  step_ok = !wr_key && mask_match;
         KEY_TWO:  step_ok = wr_key && mask_match;
         default:  step_ok = 1'b0;
      endcase
   end

   always_comb begin
      cfg_low_in   = cfg_low_ff;
      cfg_high_in  = cfg_high_ff;
      out_latch_in = out_latch_ff;
      locked_in    = locked_ff;
      lock_key_in  = lock_key_ff;
      key_step_in  = key_step_ff;
      pending_in   = pending_ff;
      read_val     = 32'h0;
      if (cmd.execute) begin
         if (req_ff.soft_reset) begin
            cfg_low_in   = CFG_RESET;
            cfg_high_in  = CFG_RESET;
            out_latch_in = 16'h0;
            locked_in    = 16'h0;
            lock_key_in  = 1'b0;
            key_step_in  = KEY_IDLE;
            pending_in   = 16'h0;
         end else if (req_ff.req_type == ACC_WRITE) begin
            case (req_ff.reg_select)
               SEL_CFG_LOW: begin
                  cfg_low_in = (cfg_low_ff & frozen_low) | (req_ff.write_data & ~frozen_low);
               end
               SEL_CFG_HIGH: begin
                  cfg_high_in = (cfg_high_ff & frozen_high)
                              | (req_ff.write_data & ~frozen_high);
               end
               SEL_OUTPUT: begin
                  out_latch_in = wr_mask;
               end
               SEL_LOCK: begin
                  if (!lock_key_ff) begin
                     locked_in = wr_mask;
                     if (step_ok) begin
                        if (key_step_ff == KEY_IDLE) begin
                           pending_in = wr_mask;
                        end
                        key_step_in = key_step_ff + 2'd1;
                     end else if (wr_key) begin
                        key_step_in = KEY_ONE;
                        pending_in  = wr_mask;
                     end else begin
                        key_step_in = KEY_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end else begin
            case (req_ff.reg_select)
               SEL_CFG_LOW:  read_val = cfg_low_ff;
               SEL_CFG_HIGH: read_val = cfg_high_ff;
               SEL_INPUT:    read_val = {16'h0, req_ff.pin_levels};
               SEL_OUTPUT:   read_val = {16'h0, out_latch_ff};
               SEL_LOCK: begin
                  read_val = {15'h0, lock_key_ff, locked_ff};
                  if (key_step_ff == KEY_THREE) begin
                     lock_key_in = 1'b1;
                  end
                  key_step_in = KEY_IDLE;
               end
               default:      read_val = 32'h0;
            endcase
         end
      end
   end

   always_comb begin
      rsp_in.read_data       = read_val;
      rsp_in.pin_drive       = out_latch_in;
      rsp_in.pin_config_low  = cfg_low_in;
      rsp_in.pin_config_high = cfg_high_in;
      rsp_in.lock_active     = lock_key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff   <= CFG_RESET;
         cfg_high_ff  <= CFG_RESET;
         out_latch_ff <= 16'h0;
         locked_ff    <= 16'h0;
         lock_key_ff  <= 1'b0;
         key_step_ff  <= KEY_IDLE;
         pending_ff   <= 16'h0;
      end else begin
         cfg_low_ff   <= cfg_low_in;
         cfg_high_ff  <= cfg_high_in;
         out_latch_ff <= out_latch_in;
         locked_ff    <= locked_in;
         lock_key_ff  <= lock_key_in;
         key_step_ff  <= key_step_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   `ASSERT_NEVER(a_key_set_seq_idle, clock, reset, lock_key_ff && (key_step_ff != KEY_IDLE))
   `ASSERT_PROP(a_key_sticky, clock, reset,
                lock_key_ff && !(cmd.execute && req_ff.soft_reset) |=> lock_key_ff)
   `ASSERT_NEVER(a_seq_mask_held, clock, reset,
                 (key_step_ff != KEY_IDLE) && (locked_ff != pending_ff))

endmodule
`default_nettype wire

/* rtl/core/gpio_lk_control.sv */
`default_nettype none
`include "gpio_port_with_config_lock_defines.svh"
module gpio_lk_control
   import gpio_lk_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   output logic        rsp_valid,
   output gpio_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = start ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.execute = (state_ff == S_EXEC);

   `ASSERT_PROP(a_accept_executes, clock, reset, start && !busy |=> state_ff == S_EXEC)
   `ASSERT_PROP(a_exec_responds, clock, reset, state_ff == S_EXEC |=> rsp_valid)
   `ASSERT_PROP(a_state_onehot, clock, reset, $onehot(state_ff))

endmodule
`default_nettype wire

/* sim/gpio_access_checker.sv */
`timescale 1ns / 100ps
module gpio_access_checker
   import gpio_lk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  gpio_req_type req_payload,
   input  logic         rsp_valid,
   input  gpio_rsp_type rsp_payload,
   output int           mismatch_count,
   output int           awaited_count
);

   logic [31:0]  cfg_low;
   logic [31:0]  cfg_high;
   logic [15:0]  drive_latch;
   logic [15:0]  lock_mask;
   logic [15:0]  armed_mask;
   logic         key_set;
   logic [1:0]   key_step;
   gpio_rsp_type awaited_rsps[$];
   gpio_rsp_type predicted;
   gpio_rsp_type oldest;

   task automatic clear_port_state();
      cfg_low     = CFG_RESET;
      cfg_high    = CFG_RESET;
      drive_latch = '0;
      lock_mask   = '0;
      armed_mask  = '0;
      key_set     = 1'b0;
      key_step    = KEY_IDLE;
   endtask

   function automatic logic [31:0] frozen_bits(input logic [7:0] pins);
      logic [31:0] bits;
      bits = '0;
      if (key_set) begin
         for (int i = 0; i < 8; i++) begin
            if (pins[i]) begin
               bits[4*i +: 4] = NIBBLE;
            end
         end
      end
      return bits;
   endfunction

   task automatic write_lock(input logic [31:0] data);
      logic [15:0] mask;
      logic        key;
      logic        in_order;
      mask = data[15:0];
      key  = data[KEY_BIT];
      if (!key_set) begin
         lock_mask = mask;
         case (key_step)
            KEY_IDLE: in_order = key;
            KEY_ONE:  in_order = !key && (mask == armed_mask);
            KEY_TWO:  in_order = key && (mask == armed_mask);
            default:  in_order = 1'b0;
         endcase
         if (in_order) begin
            if (key_step == KEY_IDLE) begin
               armed_mask = mask;
            end
            key_step = key_step + 2'd1;
         end else if (key) begin
            key_step   = KEY_ONE;
            armed_mask = mask;
         end else begin
            key_step = KEY_IDLE;
         end
      end
   endtask

   task automatic read_lock(output logic [31:0] value);
      value          = 32'(lock_mask);
      value[KEY_BIT] = key_set;
      if (key_step == KEY_THREE) begin
         key_set = 1'b1;
      end
      key_step = KEY_IDLE;
   endtask

   task automatic apply_access(input gpio_req_type req, output gpio_rsp_type rsp);
      logic [31:0] rdata;
      logic [31:0] keep;
      rdata = '0;
      if (req.soft_reset) begin
         clear_port_state();
      end else if (req.req_type == ACC_WRITE) begin
         case (req.reg_select)
            SEL_CFG_LOW: begin
               keep    = frozen_bits(lock_mask[7:0]);
               cfg_low = (cfg_low & keep) | (req.write_data & ~keep);
            end
            SEL_CFG_HIGH: begin
               keep     = frozen_bits(lock_mask[15:8]);
               cfg_high = (cfg_high & keep) | (req.write_data & ~keep);
            end
            SEL_OUTPUT: drive_latch = req.write_data[15:0];
            SEL_LOCK:   write_lock(req.write_data);
            default: ;
         endcase
      end else begin
         case (req.reg_select)
            SEL_CFG_LOW:  rdata = cfg_low;
            SEL_CFG_HIGH: rdata = cfg_high;
            SEL_INPUT:    rdata = 32'(req.pin_levels);
            SEL_OUTPUT:   rdata = 32'(drive_latch);
            SEL_LOCK:     read_lock(rdata);
            default:      rdata = '0;
         endcase
      end
      rsp.read_data       = rdata;
      rsp.pin_drive       = drive_latch;
      rsp.pin_config_low  = cfg_low;
      rsp.pin_config_high = cfg_high;
      rsp.lock_active     = key_set;
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] exp,
                                input logic [31:0] act);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at %0t: %s expected %h, got %h", $realtime, what, exp, act);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] exp,
                              input logic [31:0] act);
      if (exp !== act) begin
         flag_mismatch(what, exp, act);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_port_state();
         awaited_rsps.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsps.size() == 0) begin
               flag_mismatch("response without request, read_data", '0,
                             rsp_payload.read_data);
            end else begin
               oldest = awaited_rsps.pop_front();
               check_field("read_data", oldest.read_data, rsp_payload.read_data);
               check_field("pin_drive", 32'(oldest.pin_drive), 32'(rsp_payload.pin_drive));
               check_field("pin_config_low", oldest.pin_config_low,
                           rsp_payload.pin_config_low);
               check_field("pin_config_high", oldest.pin_config_high,
                           rsp_payload.pin_config_high);
               check_field("lock_active", 32'(oldest.lock_active),
                           32'(rsp_payload.lock_active));
            end
         end
         if (start && !busy) begin
            apply_access(req_payload, predicted);
            awaited_rsps.push_back(predicted);
         end
      end
      awaited_count = awaited_rsps.size();
   end

endmodule

/* sim/gpio_port_with_config_lock_test.sv */
`timescale 1ns / 100ps
module gpio_port_with_config_lock_test;
   import gpio_lk_pkg::*;

   localparam int         STALL_LIMIT     = 2000;
   localparam int         RANDOM_ITEMS    = 1550;
   localparam int         DRAIN_CYCLES    = 10;
   localparam int         PAUSE_INTERVAL  = 300;
   localparam logic [2:0] SEL_UNUSED_LOW  = 3'd5;
   localparam logic [2:0] SEL_UNUSED_HIGH = 3'd7;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic         rsp_valid;
   gpio_req_type req_payload;
   gpio_rsp_type rsp_payload;
   int           mismatch_total;
   int           outstanding;
   int           issued = 0;
   int           target;
   int           next_pause;
   int           pick;

   gpio_port_with_config_lock u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   gpio_access_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_total),
      .awaited_count  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("gpio_port_with_config_lock_test NOT OK");
      $finish;
   end

   function automatic gpio_req_type access(input logic kind, input logic [2:0] sel,
                                           input logic [31:0] data);
      gpio_req_type req;
      req.req_type   = kind;
      req.reg_select = sel;
      req.write_data = data;
      req.pin_levels = 16'($urandom);
      req.soft_reset = 1'b0;
      return req;
   endfunction

   function automatic gpio_req_type input_read(input logic [15:0] levels);
      gpio_req_type req;
      req            = access(ACC_READ, SEL_INPUT, 32'h0);
      req.pin_levels = levels;
      return req;
   endfunction

   function automatic logic [31:0] lock_word(input logic key, input logic [15:0] mask);
      logic [31:0] word;
      word          = $urandom;
      word[KEY_BIT] = key;
      word[15:0]    = mask;
      return word;
   endfunction

   function automatic logic [15:0] random_mask();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) begin
         return 16'h0000;
      end else if (roll == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   function automatic gpio_req_type random_access();
      return access(1'($urandom), 3'($urandom), $urandom);
   endfunction

   function automatic gpio_req_type random_other_access();
      gpio_req_type req;
      req = random_access();
      if (req.reg_select == SEL_LOCK) begin
         req.reg_select = SEL_CFG_LOW + 3'($urandom_range(0, 3));
      end
      return req;
   endfunction

   function automatic gpio_req_type soft_reset_access();
      gpio_req_type req;
      req            = random_access();
      req.soft_reset = 1'b1;
      return req;
   endfunction

   task automatic issue(input gpio_req_type req);
      if (!(issued >= 700 && issued < 1000) && $urandom_range(0, 99) < 16) begin
         repeat ($urandom_range(3, 8)) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start       <= 1'b1;
      req_payload <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
   endtask

   task automatic wait_for_responses();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic run_key_sequence();
      logic [15:0] mask;
      int          flaw;
      mask = random_mask();
      flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      issue(access(ACC_WRITE, SEL_LOCK, lock_word(1'b1, mask)));
      if (flaw == 1) begin
         issue(access(ACC_READ, SEL_LOCK, $urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
         issue(random_other_access());
      end
      issue(access(ACC_WRITE, SEL_LOCK, lock_word(flaw == 2,
            (flaw == 3) ? mask ^ (16'd1 << $urandom_range(0, 15)) : mask)));
      if ($urandom_range(0, 3) == 0) begin
         issue(random_other_access());
      end
      issue(access(ACC_WRITE, SEL_LOCK, lock_word(flaw != 4,
            (flaw == 5) ? mask ^ (16'd1 << $urandom_range(0, 15)) : mask)));
      issue(access(ACC_READ, SEL_LOCK, $urandom));
      issue(access(ACC_READ, SEL_LOCK, $urandom));
      repeat ($urandom_range(2, 6)) begin
         issue(random_other_access());
      end
      if ($urandom_range(0, 9) < 4) begin
         issue(soft_reset_access());
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(access(ACC_READ, SEL_CFG_LOW, 32'hFFFF_FFFF));
      issue(access(ACC_READ, SEL_CFG_HIGH, 32'h0));
      issue(input_read(16'hFFFF));
      issue(input_read(16'h0000));
      issue(access(ACC_READ, SEL_OUTPUT, 32'h0));
      issue(access(ACC_READ, SEL_LOCK, 32'h0));
      issue(access(ACC_READ, SEL_UNUSED_LOW, 32'h0));
      issue(access(ACC_WRITE, SEL_CFG_LOW, 32'hFFFF_FFFF));
      issue(access(ACC_WRITE, SEL_CFG_HIGH, 32'h0));
      issue(access(ACC_WRITE, SEL_INPUT, 32'hFFFF_FFFF));
      issue(access(ACC_WRITE, SEL_OUTPUT, 32'hFFFF_FFFF));
      issue(access(ACC_WRITE, SEL_UNUSED_HIGH, 32'hFFFF_FFFF));
      issue(access(ACC_READ, SEL_UNUSED_HIGH, 32'hFFFF_FFFF));
      issue(access(ACC_WRITE, SEL_LOCK, 32'h0001_0000 | 32'h8181));
      issue(access(ACC_READ, SEL_LOCK, 32'h0));
      issue(access(ACC_WRITE, SEL_LOCK, 32'hFFFF_8181));
      issue(access(ACC_WRITE, SEL_LOCK, 32'h0000_8181));
      issue(access(ACC_WRITE, SEL_LOCK, 32'hFFFF_8181));
      issue(access(ACC_READ, SEL_LOCK, 32'h0));
      issue(access(ACC_READ, SEL_LOCK, 32'h0));
      issue(access(ACC_WRITE, SEL_CFG_LOW, 32'h0));
      issue(access(ACC_WRITE, SEL_CFG_HIGH, 32'hFFFF_FFFF));
      issue(access(ACC_WRITE, SEL_LOCK, 32'h0001_0000));
      issue(soft_reset_access());
      issue(access(ACC_READ, SEL_LOCK, 32'h0));
      wait_for_responses();

      target     = issued + RANDOM_ITEMS;
      next_pause = issued + PAUSE_INTERVAL;
      while (issued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            run_key_sequence();
         end else if (pick < 43) begin
            issue(soft_reset_access());
         end else if (pick < 50) begin
            issue(access(1'($urandom), SEL_LOCK, lock_word(1'($urandom), random_mask())));
         end else begin
            issue(random_access());
         end
         if (issued >= next_pause) begin
            wait_for_responses();
            next_pause = issued + PAUSE_INTERVAL;
         end
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_total == 0 && outstanding == 0) begin
         $display("gpio_port_with_config_lock_test OK");
      end else begin
         $display("gpio_port_with_config_lock_test NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gpio_lk_pkg.sv
rtl/core/gpio_lk_datapath.sv
rtl/core/gpio_lk_control.sv
rtl/core/gpio_port_with_config_lock.sv
sim/gpio_access_checker.sv
sim/gpio_port_with_config_lock_test.sv
